@@ design/slarq_pkg.sv @@
// Shared types, constants and helper functions for the link acknowledgement sequencer.
package slarq_pkg;

    localparam int TIMER_WIDTH = 16;
    localparam int SEQ_W       = 3;
    localparam logic [SEQ_W-1:0] SEQ_MASK = 3'h7;
    localparam int ADDR_W      = 4;
    localparam int RQ_DEPTH    = 8;
    localparam int RQ_PTR_W    = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W    = RQ_PTR_W + 1;
    localparam int MAX_RES     = 3;

    localparam logic [1:0] REG_MAX_RETRIES   = 2'd0;
    localparam logic [1:0] REG_ACK_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_RESET_TIMEOUT = 2'd2;

    localparam logic [3:0]  RST_MAX_RETRIES   = 4'd3;
    localparam logic [15:0] RST_ACK_TIMEOUT   = 16'd800;
    localparam logic [15:0] RST_RESET_TIMEOUT = 16'd2500;

    typedef enum logic [2:0] {
        KIND_SEND   = 3'd0,
        KIND_DATA   = 3'd1,
        KIND_ACK    = 3'd2,
        KIND_NAK    = 3'd3,
        KIND_RSTACK = 3'd4,
        KIND_ERROR  = 3'd5,
        KIND_TICK   = 3'd6,
        KIND_RESET  = 3'd7
    } slarq_kind_t;

    typedef enum logic [3:0] {
        ACT_NONE      = 4'd0,
        ACT_TX_DATA   = 4'd1,
        ACT_TX_ACK    = 4'd2,
        ACT_TX_RESET  = 4'd3,
        ACT_SEND_OK   = 4'd4,
        ACT_SEND_FAIL = 4'd5,
        ACT_SEND_ABRT = 4'd6,
        ACT_RESET_OK  = 4'd7,
        ACT_RESET_FAIL= 4'd8,
        ACT_LINK_LOST = 4'd9,
        ACT_DELIVER   = 4'd10
    } slarq_act_t;

    typedef struct packed {
        slarq_kind_t      kind;
        logic [SEQ_W-1:0] rx_frame_number;
        logic [SEQ_W-1:0] rx_ack_number;
        logic             has_payload;
    } slarq_in_t;

    typedef struct packed {
        slarq_act_t       action;
        logic [SEQ_W-1:0] tx_frame_number;
        logic [SEQ_W-1:0] tx_ack_number;
        logic             retransmit;
        logic             last;
    } slarq_out_t;

    typedef struct packed {
        logic [3:0]  max_retries;
        logic [15:0] ack_timeout_ticks;
        logic [15:0] reset_timeout_ticks;
    } slarq_cfg_t;

    typedef struct packed {
        logic                     vld;
        logic [1:0]               cnt;
        slarq_out_t [MAX_RES-1:0] res;
    } slarq_push_t;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return (s + 3'd1) & SEQ_MASK;
    endfunction

    function automatic logic [TIMER_WIDTH-1:0] load_timer(input logic [15:0] t);
        logic [32:0] tmax;
        tmax = (33'd1 << TIMER_WIDTH) - 33'd1;
        if ({17'd0, t} > tmax) begin
            return tmax[TIMER_WIDTH-1:0];
        end
        return TIMER_WIDTH'({17'd0, t});
    endfunction

    function automatic slarq_out_t mk_res(input slarq_act_t act, input logic [SEQ_W-1:0] fn,
                                          input logic [SEQ_W-1:0] an, input logic rt);
        slarq_out_t r;
        r.action          = act;
        r.tx_frame_number = fn;
        r.tx_ack_number   = an;
        r.retransmit      = rt;
        r.last            = 1'b0;
        return r;
    endfunction

endpackage

@@ design/slarq_regs.sv @@
// APB configuration registers: retry limit and the two timeouts.
module slarq_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [slarq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output slarq_pkg::slarq_cfg_t       cfg
);
    import slarq_pkg::*;

    slarq_cfg_t cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_retries         <= RST_MAX_RETRIES;
            cfg_reg.ack_timeout_ticks   <= RST_ACK_TIMEOUT;
            cfg_reg.reset_timeout_ticks <= RST_RESET_TIMEOUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MAX_RETRIES:   cfg_reg.max_retries         <= pwdata[3:0];
                REG_ACK_TIMEOUT:   cfg_reg.ack_timeout_ticks   <= pwdata[15:0];
                REG_RESET_TIMEOUT: cfg_reg.reset_timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MAX_RETRIES:   prdata = {28'd0, cfg_reg.max_retries};
            REG_ACK_TIMEOUT:   prdata = {16'd0, cfg_reg.ack_timeout_ticks};
            REG_RESET_TIMEOUT: prdata = {16'd0, cfg_reg.reset_timeout_ticks};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

@@ design/slarq_core.sv @@
// Request register, sequencer state and single-pass event logic.
module slarq_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  slarq_pkg::slarq_in_t   s_payload,
    input  slarq_pkg::slarq_cfg_t  cfg,
    input  logic                   rq_room,
    output slarq_pkg::slarq_push_t push
);
    import slarq_pkg::*;

    logic                   in_vld_reg;
    slarq_in_t              in_reg;

    logic [SEQ_W-1:0]       nfn_reg, nfn_next;
    logic [SEQ_W-1:0]       ackn_reg, ackn_next;
    logic                   aw_reg, aw_next;
    logic [SEQ_W-1:0]       pend_reg, pend_next;
    logic [4:0]             att_reg, att_next;
    logic [TIMER_WIDTH-1:0] tmr_reg, tmr_next;
    logic                   down_reg, down_next;
    logic                   rp_reg, rp_next;

    slarq_out_t [MAX_RES-1:0] res_v;
    logic [1:0]             cnt_v;
    logic                   do_retry;
    logic                   done;
    logic                   consume;

    always_comb begin
        nfn_next  = nfn_reg;
        ackn_next = ackn_reg;
        aw_next   = aw_reg;
        pend_next = pend_reg;
        att_next  = att_reg;
        tmr_next  = tmr_reg;
        down_next = down_reg;
        rp_next   = rp_reg;
        res_v     = '0;
        cnt_v     = 2'd0;
        do_retry  = 1'b0;
        done      = aw_reg && (in_reg.rx_ack_number == seq_inc(pend_reg));

        unique case (in_reg.kind)
            KIND_SEND: begin
                if (aw_reg || down_reg || rp_reg) begin
                    res_v[cnt_v] = mk_res(ACT_SEND_FAIL, '0, '0, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end else begin
                    aw_next   = 1'b1;
                    pend_next = nfn_reg;
                    att_next  = 5'd0;
                    tmr_next  = load_timer(cfg.ack_timeout_ticks);
                    res_v[cnt_v] = mk_res(ACT_TX_DATA, nfn_reg, ackn_reg, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end
            end
            KIND_DATA: begin
                ackn_next = seq_inc(in_reg.rx_frame_number);
                res_v[cnt_v] = mk_res(ACT_TX_ACK, '0, ackn_next, 1'b0);
                cnt_v = cnt_v + 2'd1;
                if (done) begin
                    aw_next  = 1'b0;
                    nfn_next = seq_inc(pend_reg);
                    res_v[cnt_v] = mk_res(ACT_SEND_OK, '0, '0, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end
                if (in_reg.has_payload) begin
                    res_v[cnt_v] = mk_res(ACT_DELIVER, '0, '0, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end
            end
            KIND_ACK: begin
                if (done) begin
                    aw_next  = 1'b0;
                    nfn_next = seq_inc(pend_reg);
                    res_v[cnt_v] = mk_res(ACT_SEND_OK, '0, '0, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end
            end
            KIND_NAK: begin
                do_retry = aw_reg;
            end
            KIND_RSTACK: begin
                ackn_next = '0;
                nfn_next  = '0;
                if (rp_reg && !down_reg) begin
                    rp_next = 1'b0;
                    res_v[cnt_v] = mk_res(ACT_RESET_OK, '0, '0, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end
            end
            KIND_ERROR: begin
                down_next = 1'b1;
                if (aw_reg) begin
                    aw_next = 1'b0;
                    res_v[cnt_v] = mk_res(ACT_SEND_ABRT, '0, '0, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end
                res_v[cnt_v] = mk_res(ACT_LINK_LOST, '0, '0, 1'b0);
                cnt_v = cnt_v + 2'd1;
            end
            KIND_TICK: begin
                if (aw_reg || rp_reg) begin
                    if (tmr_reg > TIMER_WIDTH'(1)) begin
                        tmr_next = tmr_reg - TIMER_WIDTH'(1);
                    end else begin
                        tmr_next = '0;
                        if (aw_reg) begin
                            do_retry = 1'b1;
                        end else begin
                            rp_next = 1'b0;
                            res_v[cnt_v] = mk_res(ACT_RESET_FAIL, '0, '0, 1'b0);
                            cnt_v = cnt_v + 2'd1;
                        end
                    end
                end
            end
            KIND_RESET: begin
                if (aw_reg) begin
                    aw_next = 1'b0;
                    res_v[cnt_v] = mk_res(ACT_SEND_ABRT, '0, '0, 1'b0);
                    cnt_v = cnt_v + 2'd1;
                end
                nfn_next  = '0;
                ackn_next = '0;
                down_next = 1'b0;
                rp_next   = 1'b1;
                tmr_next  = load_timer(cfg.reset_timeout_ticks);
                res_v[cnt_v] = mk_res(ACT_TX_RESET, '0, '0, 1'b0);
                cnt_v = cnt_v + 2'd1;
            end
        endcase

        // retry never follows another result of the same event
        if (do_retry) begin
            if (att_reg < {1'b0, cfg.max_retries}) begin
                att_next = att_reg + 5'd1;
                tmr_next = load_timer(cfg.ack_timeout_ticks);
                res_v[0] = mk_res(ACT_TX_DATA, pend_reg, ackn_reg, 1'b1);
                cnt_v    = 2'd1;
            end else begin
                aw_next  = 1'b0;
                res_v[0] = mk_res(ACT_SEND_FAIL, '0, '0, 1'b0);
                res_v[1] = mk_res(ACT_LINK_LOST, '0, '0, 1'b0);
                cnt_v    = 2'd2;
            end
        end

        for (int k = 0; k < MAX_RES; k++) begin
            res_v[k].last = (cnt_v != 2'd0) && (2'(k) == cnt_v - 2'd1);
        end
    end

    assign consume  = in_vld_reg && (rq_room || cnt_v == 2'd0);
    assign s_ready  = !in_vld_reg || consume;
    assign push.vld = consume && (cnt_v != 2'd0);
    assign push.cnt = cnt_v;
    assign push.res = res_v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            nfn_reg    <= '0;
            ackn_reg   <= '0;
            aw_reg     <= 1'b0;
            pend_reg   <= '0;
            att_reg    <= '0;
            tmr_reg    <= '0;
            down_reg   <= 1'b0;
            rp_reg     <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (consume) begin
                nfn_reg  <= nfn_next;
                ackn_reg <= ackn_next;
                aw_reg   <= aw_next;
                pend_reg <= pend_next;
                att_reg  <= att_next;
                tmr_reg  <= tmr_next;
                down_reg <= down_next;
                rp_reg   <= rp_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
    end

`ifndef SYNTHESIS
    a_no_send_in_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !(aw_reg && rp_reg))
        else $error("awaiting ack while reset pending");

    a_down_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        down_reg |-> !aw_reg)
        else $error("awaiting ack while link down");
`endif

endmodule

@@ design/slarq_outq.sv @@
// Result queue: takes up to three results a cycle, hands out one a cycle while m_ready is high.
module slarq_outq (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  slarq_pkg::slarq_push_t push,
    output logic                   rq_room,
    output logic                   m_valid,
    input  logic                   m_ready,
    output slarq_pkg::slarq_out_t  m_payload
);
    import slarq_pkg::*;

    slarq_out_t            mem_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wptr_reg, wptr_next;
    logic [RQ_PTR_W-1:0]   rptr_reg, rptr_next;
    logic [RQ_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [RQ_CNT_W-1:0]   add;
    logic                  pop;

    assign m_valid   = cnt_reg != '0;
    assign m_payload = mem_reg[rptr_reg];
    assign pop       = m_valid && m_ready;
    assign rq_room   = cnt_reg <= RQ_CNT_W'(RQ_DEPTH - MAX_RES);
    assign add       = push.vld ? RQ_CNT_W'(push.cnt) : '0;

    always_comb begin
        wptr_next = wptr_reg + RQ_PTR_W'(add);
        rptr_next = rptr_reg + RQ_PTR_W'(pop);
        cnt_next  = cnt_reg + add - RQ_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.vld) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < push.cnt) begin
                    mem_reg[wptr_reg + RQ_PTR_W'(k)] <= push.res[k];
                end
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= RQ_CNT_W'(RQ_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld |-> (rq_room && push.cnt != 2'd0))
        else $error("push without room or without results");

    a_push_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.vld |-> push.res[push.cnt - 2'd1].last)
        else $error("final result of request not marked last");
`endif

endmodule

@@ design/serial_link_ack_retry_sequencer_top.sv @@
// Top level of the serial link stop-and-wait acknowledgement sequencer.
// Each request is one link event (send, received frame, tick or reset) and yields zero to three
// results, the final one flagged by last. A request is registered on acceptance and processed
// from that register in one pass, its results going into an eight-entry result queue; a new
// request can be taken every cycle while the queue has room. The result port delivers one
// result per cycle while m_ready is high, so the sustained rate is one request per cycle when
// each gives at most one result and the result port is not stalled.
// Registers (APB, byte addresses 0, 4, 8): max_retries, ack_timeout_ticks,
// reset_timeout_ticks; write them only while the block is idle.
module serial_link_ack_retry_sequencer_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  slarq_pkg::slarq_in_t         s_payload,
    output logic                         m_valid,
    input  logic                         m_ready,
    output slarq_pkg::slarq_out_t        m_payload,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slarq_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import slarq_pkg::*;

    slarq_cfg_t  cfg;
    slarq_push_t push;
    logic        rq_room;

    slarq_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slarq_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .cfg       (cfg),
        .rq_room   (rq_room),
        .push      (push)
    );

    slarq_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .rq_room   (rq_room),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ tb/sv/serial_link_ack_retry_sequencer_top_tb.sv @@
// Self-checking testbench for the serial link ack/retry sequencer: directed and random requests.
`timescale 1ns / 1ps
module serial_link_ack_retry_sequencer_top_tb;
    import slarq_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    slarq_in_t             s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    slarq_out_t            m_payload;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_W-1:0]     paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic [31:0]           prdata;
    logic                  pready;

    slarq_in_t  pending_reqs[$];
    slarq_out_t due_results[$];
    slarq_out_t step_out[$];
    int         err_count = 0;
    bit         calm      = 1'b0;

    // link state as the block should hold it
    logic [3:0]  cfg_retries = RST_MAX_RETRIES;
    logic [15:0] cfg_ack_to  = RST_ACK_TIMEOUT;
    logic [15:0] cfg_rst_to  = RST_RESET_TIMEOUT;
    logic [2:0]  nxt_fn      = '0;
    logic [2:0]  ack_no      = '0;
    logic [2:0]  pend_fn     = '0;
    logic        awaiting    = 1'b0;
    logic        link_down   = 1'b0;
    logic        rst_pending = 1'b0;
    logic [4:0]  attempts    = '0;
    logic [15:0] wait_cnt    = '0;

    serial_link_ack_retry_sequencer_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic note(input slarq_act_t act, input logic [2:0] fn, input logic [2:0] an,
                        input logic rt);
        slarq_out_t r;
        r.action          = act;
        r.tx_frame_number = fn;
        r.tx_ack_number   = an;
        r.retransmit      = rt;
        r.last            = 1'b0;
        step_out.push_back(r);
    endtask

    task automatic finish_send();
        awaiting = 1'b0;
        nxt_fn   = pend_fn + 3'd1;
        note(ACT_SEND_OK, 3'd0, 3'd0, 1'b0);
    endtask

    task automatic retry_or_fail();
        if (attempts < {1'b0, cfg_retries}) begin
            attempts = attempts + 5'd1;
            wait_cnt = cfg_ack_to;
            note(ACT_TX_DATA, pend_fn, ack_no, 1'b1);
        end else begin
            awaiting = 1'b0;
            note(ACT_SEND_FAIL, 3'd0, 3'd0, 1'b0);
            note(ACT_LINK_LOST, 3'd0, 3'd0, 1'b0);
        end
    endtask

    task automatic advance_link(input slarq_in_t ev);
        logic acked;
        step_out.delete();
        case (ev.kind)
            KIND_SEND: begin
                if (awaiting || link_down || rst_pending) begin
                    note(ACT_SEND_FAIL, 3'd0, 3'd0, 1'b0);
                end else begin
                    awaiting = 1'b1;
                    pend_fn  = nxt_fn;
                    attempts = '0;
                    wait_cnt = cfg_ack_to;
                    note(ACT_TX_DATA, pend_fn, ack_no, 1'b0);
                end
            end
            KIND_DATA: begin
                ack_no = ev.rx_frame_number + 3'd1;
                acked  = awaiting && (ev.rx_ack_number == pend_fn + 3'd1);
                note(ACT_TX_ACK, 3'd0, ack_no, 1'b0);
                if (acked) finish_send();
                if (ev.has_payload) note(ACT_DELIVER, 3'd0, 3'd0, 1'b0);
            end
            KIND_ACK: begin
                if (awaiting && (ev.rx_ack_number == pend_fn + 3'd1)) finish_send();
            end
            KIND_NAK: begin
                if (awaiting) retry_or_fail();
            end
            KIND_RSTACK: begin
                ack_no = '0;
                nxt_fn = '0;
                if (rst_pending && !link_down) begin
                    rst_pending = 1'b0;
                    note(ACT_RESET_OK, 3'd0, 3'd0, 1'b0);
                end
            end
            KIND_ERROR: begin
                link_down = 1'b1;
                if (awaiting) begin
                    awaiting = 1'b0;
                    note(ACT_SEND_ABRT, 3'd0, 3'd0, 1'b0);
                end
                note(ACT_LINK_LOST, 3'd0, 3'd0, 1'b0);
            end
            KIND_TICK: begin
                if (awaiting || rst_pending) begin
                    if (wait_cnt > 16'd1) begin
                        wait_cnt = wait_cnt - 16'd1;
                    end else begin
                        wait_cnt = '0;
                        if (awaiting) begin
                            retry_or_fail();
                        end else begin
                            rst_pending = 1'b0;
                            note(ACT_RESET_FAIL, 3'd0, 3'd0, 1'b0);
                        end
                    end
                end
            end
            default: begin
                if (awaiting) begin
                    awaiting = 1'b0;
                    note(ACT_SEND_ABRT, 3'd0, 3'd0, 1'b0);
                end
                nxt_fn      = '0;
                ack_no      = '0;
                link_down   = 1'b0;
                rst_pending = 1'b1;
                wait_cnt    = cfg_rst_to;
                note(ACT_TX_RESET, 3'd0, 3'd0, 1'b0);
            end
        endcase
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
        foreach (step_out[i]) due_results.push_back(step_out[i]);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) advance_link(s_payload);
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                    s_valid   <= 1'b1;
                    s_payload <= pending_reqs.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // monitor
    always @(posedge aclk) begin : watch_results
        slarq_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result, action %0d", m_payload.action);
                    err_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("action", want.action, m_payload.action);
                    check_field("tx_frame_number", want.tx_frame_number,
                                m_payload.tx_frame_number);
                    check_field("tx_ack_number", want.tx_ack_number, m_payload.tx_ack_number);
                    check_field("retransmit", want.retransmit, m_payload.retransmit);
                    check_field("last", want.last, m_payload.last);
                end
            end
            m_ready <= calm || $urandom_range(99) >= 34;
        end
    end

    task automatic queue_req(input slarq_kind_t kind, input logic [2:0] fn,
                             input logic [2:0] an, input logic pl);
        slarq_in_t ev;
        ev.kind            = kind;
        ev.rx_frame_number = fn;
        ev.rx_ack_number   = an;
        ev.has_payload     = pl;
        pending_reqs.push_back(ev);
    endtask

    // random mix of link events, ack numbers mostly right, plus noise
    function automatic slarq_in_t pick_request();
        slarq_in_t ev;
        int        roll;
        roll = $urandom_range(99);
        if (roll < 18)      ev.kind = KIND_SEND;
        else if (roll < 36) ev.kind = KIND_ACK;
        else if (roll < 50) ev.kind = KIND_DATA;
        else if (roll < 60) ev.kind = KIND_NAK;
        else if (roll < 80) ev.kind = KIND_TICK;
        else if (roll < 85) ev.kind = KIND_RSTACK;
        else if (roll < 89) ev.kind = KIND_ERROR;
        else                ev.kind = KIND_RESET;
        ev.rx_frame_number = 3'($urandom_range(7));
        ev.rx_ack_number   = ($urandom_range(3) != 0) ? nxt_fn + 3'd1 : 3'($urandom_range(7));
        ev.has_payload     = 1'($urandom_range(1));
        return ev;
    endfunction

    task automatic settle();
        int guard;
        guard = 0;
        while ((pending_reqs.size() != 0 || s_valid || due_results.size() != 0)
               && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (10) @(posedge aclk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            err_count++;
            due_results.delete();
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MAX_RETRIES: cfg_retries = val[3:0];
            REG_ACK_TIMEOUT: cfg_ack_to  = val[15:0];
            default:         cfg_rst_to  = val[15:0];
        endcase
    endtask

    task automatic run_phase(input logic [3:0] retries, input logic [15:0] ack_to,
                             input logic [15:0] rst_to, input int count, input bit quiet);
        apb_write(REG_MAX_RETRIES, {28'd0, retries});
        apb_write(REG_ACK_TIMEOUT, {16'd0, ack_to});
        apb_write(REG_RESET_TIMEOUT, {16'd0, rst_to});
        calm = quiet;
        repeat (count) begin
            while (pending_reqs.size() >= 2) @(posedge aclk);
            pending_reqs.push_back(pick_request());
        end
        settle();
        calm = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values
        queue_req(KIND_SEND,   3'd0, 3'd0, 1'b0);
        queue_req(KIND_SEND,   3'd7, 3'd7, 1'b1);   // busy: refused
        queue_req(KIND_NAK,    3'd0, 3'd0, 1'b0);
        queue_req(KIND_ACK,    3'd0, 3'd0, 1'b0);   // wrong number
        queue_req(KIND_DATA,   3'd7, 3'd1, 1'b1);   // ack, completion, delivery
        queue_req(KIND_ACK,    3'd7, 3'd7, 1'b1);   // stray
        queue_req(KIND_NAK,    3'd7, 3'd7, 1'b1);   // stray
        queue_req(KIND_TICK,   3'd7, 3'd7, 1'b1);   // idle tick
        queue_req(KIND_SEND,   3'd0, 3'd0, 1'b0);
        queue_req(KIND_NAK,    3'd0, 3'd0, 1'b0);
        queue_req(KIND_NAK,    3'd0, 3'd0, 1'b0);
        queue_req(KIND_NAK,    3'd0, 3'd0, 1'b0);
        queue_req(KIND_NAK,    3'd0, 3'd0, 1'b0);   // retries used up
        queue_req(KIND_SEND,   3'd0, 3'd0, 1'b0);
        queue_req(KIND_ERROR,  3'd0, 3'd0, 1'b0);
        queue_req(KIND_SEND,   3'd0, 3'd0, 1'b0);   // link down
        queue_req(KIND_RSTACK, 3'd0, 3'd0, 1'b0);   // nothing pending
        queue_req(KIND_RESET,  3'd0, 3'd0, 1'b0);
        queue_req(KIND_RSTACK, 3'd0, 3'd0, 1'b0);
        queue_req(KIND_SEND,   3'd0, 3'd0, 1'b0);
        queue_req(KIND_RESET,  3'd0, 3'd0, 1'b0);   // aborts the send
        queue_req(KIND_ERROR,  3'd7, 3'd7, 1'b0);   // reset stays pending
        queue_req(KIND_RSTACK, 3'd7, 3'd7, 1'b1);   // link down: no report
        queue_req(KIND_RESET,  3'd0, 3'd0, 1'b0);
        queue_req(KIND_DATA,   3'd0, 3'd7, 1'b0);
        settle();

        run_phase(4'd0,  16'd1,     16'd1,     30, 1'b0);
        run_phase(4'd15, 16'd2,     16'd3,     30, 1'b0);
        run_phase(4'd1,  16'd0,     16'd0,     30, 1'b0);
        run_phase(4'd2,  16'd3,     16'd2,     30, 1'b1);
        run_phase(4'd15, 16'd65535, 16'd65535, 30, 1'b0);
        run_phase(4'd4,  16'd1,     16'd2,     30, 1'b0);

        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule
